// ===== hdl/eba_pkg.sv =====
// ----------------------------------------------------------------------------
// eba_pkg
// Types and codes shared by the 8-bit ALU with accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

package eba_pkg;

    // Write target of one input transfer. Code 3 selects no port.
    typedef enum logic [1:0] {
        CMD_LEFT  = 2'd0,
        CMD_OP    = 2'd1,
        CMD_RIGHT = 2'd2
    } t_cmd;

    // Operation codes. Codes above OP_RACC give a zero result.
    typedef enum logic [7:0] {
        OP_ADD  = 8'd0,
        OP_SUB  = 8'd1,
        OP_AND  = 8'd2,
        OP_OR   = 8'd3,
        OP_XOR  = 8'd4,
        OP_NOT  = 8'd5,
        OP_LAND = 8'd6,
        OP_LOR  = 8'd7,
        OP_LXOR = 8'd8,
        OP_LNOT = 8'd9,
        OP_SHL  = 8'd10,
        OP_SHR  = 8'd11,
        OP_GT   = 8'd12,
        OP_LT   = 8'd13,
        OP_GE   = 8'd14,
        OP_LE   = 8'd15,
        OP_EQ   = 8'd16,
        OP_MUL  = 8'd17,
        OP_NEG  = 8'd18,
        OP_REV  = 8'd19,
        OP_ROL  = 8'd20,
        OP_ROR  = 8'd21,
        OP_AOPL = 8'd22,
        OP_AOPR = 8'd23,
        OP_LACC = 8'd24,
        OP_RACC = 8'd25
    } t_op;

    localparam int unsigned DATA_W = 8;

    // Architectural state of the ALU, passed from the state stage to the
    // result logic.
    typedef struct packed {
        logic [DATA_W-1:0] op_code;
        logic [DATA_W-1:0] left_operand;
        logic [DATA_W-1:0] right_operand;
        logic [DATA_W-1:0] left_accum;
        logic [DATA_W-1:0] right_accum;
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/eba_state.sv =====
// ----------------------------------------------------------------------------
// eba_state
// Port registers and accumulators, updated on each accepted write.
// ----------------------------------------------------------------------------
`default_nettype none

module eba_state (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire logic [1:0]            i_cmd,
    input  wire logic [7:0]            i_wr_value,
    output eba_pkg::t_state            o_state
);
    import eba_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   to_accum;

    always_comb begin
        n_state  = r_state;
        to_accum = (r_state.op_code == OP_AOPL) || (r_state.op_code == OP_AOPR);
        unique case (i_cmd)
            CMD_LEFT: begin
                if (to_accum) begin
                    n_state.left_accum = i_wr_value;
                end else begin
                    n_state.left_operand = i_wr_value;
                end
            end
            CMD_OP: begin
                n_state.op_code = i_wr_value;
            end
            CMD_RIGHT: begin
                if (to_accum) begin
                    n_state.right_accum = i_wr_value;
                end else begin
                    n_state.right_operand = i_wr_value;
                end
            end
            default: begin
                n_state = r_state; // unused port
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_load) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

// ===== hdl/eba_compute.sv =====
// ----------------------------------------------------------------------------
// eba_compute
// Result byte of the current state: one pass of operation decode.
// ----------------------------------------------------------------------------
`default_nettype none

module eba_compute (
    input  wire eba_pkg::t_state  i_state,
    output logic [7:0]            o_result
);
    import eba_pkg::*;

    logic [7:0]  l;
    logic [7:0]  r;
    logic [15:0] prod;
    logic [15:0] rol_w;
    logic [15:0] ror_w;
    logic [7:0]  rev;
    logic        big_shift;

    assign l         = i_state.left_operand;
    assign r         = i_state.right_operand;
    assign prod      = 16'(l) * 16'(r);
    assign rol_w     = {l, l} << r[2:0];
    assign ror_w     = {l, l} >> r[2:0];
    assign big_shift = (r[7:3] != 5'd0);

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            rev[i] = l[7-i];
        end
    end

    always_comb begin
        unique case (i_state.op_code)
            OP_ADD:  o_result = l + r;
            OP_SUB:  o_result = l - r;
            OP_AND:  o_result = l & r;
            OP_OR:   o_result = l | r;
            OP_XOR:  o_result = l ^ r;
            OP_NOT:  o_result = ~l;
            OP_LAND: o_result = {7'd0, (l != 8'd0) && (r != 8'd0)};
            OP_LOR:  o_result = {7'd0, (l != 8'd0) || (r != 8'd0)};
            OP_LXOR: o_result = {7'd0, (l != 8'd0) ^ (r != 8'd0)};
            OP_LNOT: o_result = {7'd0, l == 8'd0};
            OP_SHL:  o_result = big_shift ? 8'd0 : (l << r[2:0]);
            OP_SHR:  o_result = big_shift ? 8'd0 : (l >> r[2:0]);
            OP_GT:   o_result = {7'd0, l > r};
            OP_LT:   o_result = {7'd0, l < r};
            OP_GE:   o_result = {7'd0, l >= r};
            OP_LE:   o_result = {7'd0, l <= r};
            OP_EQ:   o_result = {7'd0, l == r};
            OP_MUL:  o_result = prod[7:0];
            OP_NEG:  o_result = 8'd0 - l;
            OP_REV:  o_result = rev;
            OP_ROL:  o_result = rol_w[15:8];
            OP_ROR:  o_result = ror_w[7:0];
            OP_AOPL: o_result = l;
            OP_AOPR: o_result = r;
            OP_LACC: o_result = i_state.left_accum;
            OP_RACC: o_result = i_state.right_accum;
            default: o_result = 8'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/eba_out.sv =====
// ----------------------------------------------------------------------------
// eba_out
// Result register with its valid flag on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module eba_out (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire logic [7:0]  i_result,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_alu_out
);
    logic       r_valid;
    logic [7:0] r_alu_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_alu_out <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_alu_out   = r_alu_out;

endmodule

`default_nettype wire

// ===== hdl/eight_bit_alu_with_accumulators.sv =====
// ----------------------------------------------------------------------------
// eight_bit_alu_with_accumulators
// 8-bit ALU with port writes, two accumulators and a registered result.
// ----------------------------------------------------------------------------
//
//  channel | valid       | ready        | payload
//  --------+-------------+--------------+---------------------
//  input   | i_in_valid  | o_in_ready   | i_cmd, i_wr_value
//  output  | o_out_valid | i_out_ready  | o_alu_out
//
// One transfer in, one result out, at one transfer per cycle sustained while the output is not stalled.
// The write lands in the state registers, then the ALU decode of that
// state is captured in the result register.
// Reset clears all state (operands, accumulators, operation) and both
// valid flags. When the result register is stalled the state stage keeps
// its item, and input is refused only while both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module eight_bit_alu_with_accumulators (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_wr_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_alu_out
);
    import eba_pkg::*;

    t_state     state;
    logic [7:0] result;
    logic       in_xfer;
    logic       advance;   // state stage may hand its item to the result reg
    logic       r_s1_valid;

    // Result register frees up when empty or when its result is taken.
    assign advance    = !o_out_valid || i_out_ready;
    // The state registers may change only once their item has moved on.
    assign o_in_ready = !r_s1_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Stage one: item in the state registers, not yet in the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    eba_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_xfer),
        .i_cmd      (i_cmd),
        .i_wr_value (i_wr_value),
        .o_state    (state)
    );

    eba_compute u_compute (
        .i_state  (state),
        .o_result (result)
    );

    eba_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (r_s1_valid && advance),
        .i_result    (result),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_alu_out   (o_alu_out)
    );

endmodule

`default_nettype wire

// ===== hdl/eba_checker.sv =====
// ----------------------------------------------------------------------------
// eba_checker
// Port-level checks on the ALU's handshakes and latency.
// ----------------------------------------------------------------------------
`default_nettype none

module eba_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        o_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_wr_value,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  o_alu_out
);

    // a refused write is held until its transfer
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_cmd) && $stable(i_wr_value))
        else $error("input changed while waiting");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_alu_out))
        else $error("result changed while stalled");

    // an accepted write leads to a valid result, through the state and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> ##1 o_out_valid)
        else $error("result missing after transfer");

    // input is refused only when the result register is full
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

endmodule

bind eight_bit_alu_with_accumulators eba_checker u_eba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_cmd       (i_cmd),
    .i_wr_value  (i_wr_value),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_alu_out   (o_alu_out)
);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 8-bit ALU with accumulators. Port writes come
// from a queue and go through a valid/ready driver. Each accepted transfer
// updates a local model of the ALU state, which predicts the result byte.
// Each result transfer is checked in order against those predictions, under
// changing amounts of idling on both sides.
// ----------------------------------------------------------------------------

module testbench;
    import eba_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_WRITES = 1150;
    localparam int STALL_LIMIT   = 400;   // cycles with no transfer on either side
    localparam int DRAIN_CYCLES  = 8;     // margin after both queues run empty

    // Port 3 selects nothing; the result is simply presented again.
    localparam logic [1:0] CMD_NONE        = 2'd3;
    // Codes past the last operation give zero.
    localparam logic [7:0] OP_FIRST_UNUSED = 8'd26;
    localparam logic [7:0] OP_LAST_UNUSED  = 8'hFF;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] value;
    } t_port_write;

    // Bench-driven signals, all known from time zero.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [1:0] in_cmd    = 2'd0;
    logic [7:0] in_value  = 8'd0;
    logic       out_ready = 1'b0;

    wire        in_ready;
    wire        out_valid;
    wire  [7:0] alu_out;

    eight_bit_alu_with_accumulators i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_cmd      (in_cmd),
        .i_wr_value (in_value),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_alu_out  (alu_out)
    );

    always #CLK_HALF clk = ~clk;

    t_port_write write_queue[$];     // writes not yet transferred
    logic [7:0]  result_queue[$];    // result bytes still owed by the block
    t_state      alu_state = '0;     // local copy of the ALU state
    int          errors          = 0;
    int          accepted_writes = 0;
    int          total_writes    = 0;
    int          stall_count     = 0;
    bit          in_fire         = 1'b0;   // input transfer at the last rising edge

    // Result byte for a given state.
    function automatic logic [7:0] alu_result(t_state st);
        logic [7:0]  l;
        logic [7:0]  r;
        logic [15:0] twin;
        logic [7:0]  res;
        l   = st.left_operand;
        r   = st.right_operand;
        res = 8'd0;
        case (st.op_code)
            OP_ADD:  res = l + r;
            OP_SUB:  res = l - r;
            OP_AND:  res = l & r;
            OP_OR:   res = l | r;
            OP_XOR:  res = l ^ r;
            OP_NOT:  res = ~l;
            OP_LAND: res = {7'd0, (l != 8'd0) && (r != 8'd0)};
            OP_LOR:  res = {7'd0, (l != 8'd0) || (r != 8'd0)};
            OP_LXOR: res = {7'd0, (l != 8'd0) ^ (r != 8'd0)};
            OP_LNOT: res = {7'd0, l == 8'd0};
            OP_SHL:  res = (r >= 8'd8) ? 8'd0 : l << r;
            OP_SHR:  res = (r >= 8'd8) ? 8'd0 : l >> r;
            OP_GT:   res = {7'd0, l > r};
            OP_LT:   res = {7'd0, l < r};
            OP_GE:   res = {7'd0, l >= r};
            OP_LE:   res = {7'd0, l <= r};
            OP_EQ:   res = {7'd0, l == r};
            OP_MUL:  res = l * r;
            OP_NEG:  res = 8'd0 - l;
            OP_REV:  for (int b = 0; b < 8; b++) res[b] = l[7-b];
            OP_ROL: begin
                twin = {l, l} << r[2:0];
                res  = twin[15:8];
            end
            OP_ROR: begin
                twin = {l, l} >> r[2:0];
                res  = twin[7:0];
            end
            OP_AOPL: res = l;
            OP_AOPR: res = r;
            OP_LACC: res = st.left_accum;
            OP_RACC: res = st.right_accum;
            default: res = 8'd0;
        endcase
        return res;
    endfunction

    // Applies one port write to the local state and queues the byte it yields.
    task automatic apply_write(t_port_write w);
        logic to_accum;
        to_accum = (alu_state.op_code == OP_AOPL) || (alu_state.op_code == OP_AOPR);
        case (w.cmd)
            CMD_LEFT: begin
                if (to_accum) alu_state.left_accum = w.value;
                else          alu_state.left_operand = w.value;
            end
            CMD_OP: alu_state.op_code = w.value;
            CMD_RIGHT: begin
                if (to_accum) alu_state.right_accum = w.value;
                else          alu_state.right_operand = w.value;
            end
            default: ;
        endcase
        result_queue.push_back(alu_result(alu_state));
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch @ %0t ns: %s", $time, what);
        errors++;
    endtask

    task automatic add_write(logic [1:0] cmd, logic [7:0] value);
        write_queue.push_back('{cmd: cmd, value: value});
    endtask

    // Operand bytes lean towards the edges and towards small shift counts.
    function automatic logic [7:0] pick_operand();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h01;
            4:       return 8'($urandom_range(9));
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly defined operations; the odd write takes any code, mostly an unused one.
    function automatic logic [7:0] pick_op();
        if ($urandom_range(99) < 88)
            return 8'($urandom_range(int'(OP_RACC)));
        return 8'($urandom_range(int'(OP_LAST_UNUSED)));
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge. An input transfer
    // updates the model; a result transfer is checked against the oldest
    // prediction. The watchdog counts edges with no transfer at all.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        logic [7:0] expected_byte;
        if (rst_n) begin
            in_fire = in_valid && in_ready;
            if (in_fire) begin
                apply_write('{cmd: in_cmd, value: in_value});
                void'(write_queue.pop_front());
                accepted_writes++;
            end
            if (out_valid && out_ready) begin
                if (result_queue.size() == 0) begin
                    report_mismatch($sformatf("result %02h with nothing expected", alu_out));
                end else begin
                    expected_byte = result_queue.pop_front();
                    if (alu_out !== expected_byte)
                        report_mismatch($sformatf("alu_out %02h, expected %02h",
                                                  alu_out, expected_byte));
                end
            end
            if (in_fire || (out_valid && out_ready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: changes inputs at the falling edge. A held item stays put until
    // its transfer; otherwise the next queued write goes out unless the
    // sender idles this cycle. Idling runs in three phases by progress:
    // sender-light/receiver-heavy, then swapped, then none at all.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin : driver
        int send_idle_pct;
        int recv_idle_pct;
        if (accepted_writes < total_writes / 3) begin
            send_idle_pct = 37;
            recv_idle_pct = 80;
        end else if (accepted_writes < (2 * total_writes) / 3) begin
            send_idle_pct = 80;
            recv_idle_pct = 37;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end

        out_ready <= ($urandom_range(99) >= recv_idle_pct);

        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (write_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_cmd   <= write_queue[0].cmd;
                in_value <= write_queue[0].value;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int sel;
        // Directed: operand extremes, wrap-around, large shifts, rotates,
        // accumulator routing, unknown codes and the unused port.
        add_write(CMD_LEFT,  8'hFF);
        add_write(CMD_RIGHT, 8'h01);
        add_write(CMD_OP,    OP_ADD);          // wraps to zero
        add_write(CMD_OP,    OP_SUB);
        add_write(CMD_RIGHT, 8'h08);
        add_write(CMD_OP,    OP_SHL);          // shift of eight gives zero
        add_write(CMD_OP,    OP_SHR);
        add_write(CMD_RIGHT, 8'h07);
        add_write(CMD_OP,    OP_ROL);
        add_write(CMD_OP,    OP_ROR);
        add_write(CMD_OP,    OP_MUL);
        add_write(CMD_OP,    OP_AOPL);         // operand writes now go to accumulators
        add_write(CMD_LEFT,  8'hA5);
        add_write(CMD_RIGHT, 8'h5A);
        add_write(CMD_OP,    OP_LACC);
        add_write(CMD_OP,    OP_RACC);
        add_write(CMD_OP,    OP_LAST_UNUSED);
        add_write(CMD_OP,    OP_FIRST_UNUSED);
        add_write(CMD_NONE,  8'hFF);
        add_write(CMD_LEFT,  8'h00);
        add_write(CMD_OP,    OP_LNOT);
        add_write(CMD_OP,    OP_NEG);
        add_write(CMD_LEFT,  8'h80);
        add_write(CMD_OP,    OP_REV);

        for (int i = 0; i < RANDOM_WRITES; i++) begin
            sel = $urandom_range(99);
            if (sel < 30)      add_write(CMD_LEFT,  pick_operand());
            else if (sel < 60) add_write(CMD_RIGHT, pick_operand());
            else if (sel < 95) add_write(CMD_OP,    pick_op());
            else               add_write(CMD_NONE,  8'($urandom));
        end
        total_writes = write_queue.size();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (write_queue.size() != 0 || result_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
